// File: hdl/hsl_to_rgb_converter_macros.svh
// assertion macros for the converter rtl
`ifndef HSL_TO_RGB_CONVERTER_MACROS_SVH
`define HSL_TO_RGB_CONVERTER_MACROS_SVH

// condition holds at every clock edge out of reset
`define HSL2RGB_ASSERT_HOLDS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define HSL2RGB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define HSL2RGB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/hsl2rgb_pkg.sv
package hsl2rgb_pkg;

    // default fixed point format of saturation, luminance and alpha
    localparam int FRAC_BITS_DEF = 12;

    // payload widths
    localparam int HUE_W = 9;
    localparam int Q_W   = 13;
    localparam int CH_W  = 8;

    // pipeline depth
    localparam int STAGES = 4;

    // colour wheel constants
    localparam int SECTOR_DEG = 60;
    localparam logic [HUE_W-1:0] HUE_MAX = HUE_W'(360);
    localparam int CHAN_MAX = 255;

    // 255*v/den rounded: numerator and denominator share a factor of 15,
    // leaving a multiply by 17 and a power of two shift
    localparam int RND_MUL = CHAN_MAX / 15;

    // width of the triangle weight, 0 to 60
    localparam int K_W = 6;

    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } t_sector;

    // first hue of each 60 degree sector
    function automatic logic [HUE_W-1:0] sector_start(t_sector sec);
        logic [HUE_W-1:0] start;
        unique case (sec)
            SEC_0:   start = HUE_W'(0);
            SEC_1:   start = HUE_W'(SECTOR_DEG);
            SEC_2:   start = HUE_W'(2 * SECTOR_DEG);
            SEC_3:   start = HUE_W'(3 * SECTOR_DEG);
            SEC_4:   start = HUE_W'(4 * SECTOR_DEG);
            SEC_5:   start = HUE_W'(5 * SECTOR_DEG);
            default: start = HUE_W'(0);
        endcase
        return start;
    endfunction

endpackage

// File: hdl/hsl2rgb_in_if.sv
// hsl colour channel
interface hsl2rgb_in_if import hsl2rgb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [HUE_W-1:0] hue_deg;
    logic [Q_W-1:0]   sat_q;
    logic [Q_W-1:0]   lum_q;
    logic [Q_W-1:0]   alpha_q;

    modport source (
        output valid, hue_deg, sat_q, lum_q, alpha_q,
        input  ready
    );

    modport sink (
        input  valid, hue_deg, sat_q, lum_q, alpha_q,
        output ready
    );
endinterface

// File: hdl/hsl2rgb_out_if.sv
// rgb colour channel
interface hsl2rgb_out_if import hsl2rgb_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic [Q_W-1:0]  alpha_out;
    logic            range_error;

    modport source (
        output valid, red_out, green_out, blue_out, alpha_out, range_error,
        input  ready
    );

    modport sink (
        input  valid, red_out, green_out, blue_out, alpha_out, range_error,
        output ready
    );
endinterface

// File: hdl/hsl2rgb_dp.sv
module hsl2rgb_dp import hsl2rgb_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic [STAGES-1:0] i_en,
    input  logic [HUE_W-1:0]  i_hue_deg,
    input  logic [Q_W-1:0]    i_sat_q,
    input  logic [Q_W-1:0]    i_lum_q,
    input  logic [Q_W-1:0]    i_alpha_q,
    output logic [CH_W-1:0]   o_red_out,
    output logic [CH_W-1:0]   o_green_out,
    output logic [CH_W-1:0]   o_blue_out,
    output logic [Q_W-1:0]    o_alpha_out,
    output logic              o_range_error
);

    // widths: a = 1-|2l-1| in units of one, c2 = a*s, channel numerators
    // over one*one*120, rounding sum
    localparam int A_W    = FRAC_BITS + 1;
    localparam int CMP_W  = (FRAC_BITS + 1 > Q_W + 1) ? FRAC_BITS + 1 : Q_W + 1;
    localparam int C2_W   = A_W + Q_W;
    localparam int V_W    = 2 * FRAC_BITS + 7;
    localparam int R_W    = 2 * FRAC_BITS + 11;
    localparam int RND_SH = 2 * FRAC_BITS + 3;

    localparam logic [CMP_W-1:0] ONE_C  = CMP_W'(1) << FRAC_BITS;
    localparam logic [R_W-1:0]   HALF_R = R_W'(1) << (2 * FRAC_BITS + 2);

    // round half up of 255*v/(one*one*120)
    function automatic logic [CH_W-1:0] to_byte(logic [V_W-1:0] v);
        logic [R_W-1:0] acc;
        acc = R_W'(v) * R_W'(RND_MUL) + HALF_R;
        return acc[RND_SH +: CH_W];
    endfunction

    // ---------------- stage 1: clamp, sector, weights ----------------
    logic                 w_hue_over, w_sat_over, w_lum_over, w_alpha_over;
    logic [HUE_W-1:0]     w_hue;
    logic [Q_W-1:0]       w_sat, w_lum, w_alpha;
    t_sector              w_sec;
    logic [HUE_W-1:0]     w_off;
    logic [K_W-1:0]       w_k;
    logic [CMP_W-1:0]     w_two_l, w_dist;
    logic [A_W-1:0]       w_a;

    t_sector              r1_sec;
    logic [K_W-1:0]       r1_k;
    logic [A_W-1:0]       r1_a;
    logic [Q_W-1:0]       r1_sat, r1_lum, r1_alpha;
    logic                 r1_err;

    // range clamping
    always_comb begin
        w_hue_over   = i_hue_deg > HUE_MAX;
        w_sat_over   = CMP_W'(i_sat_q) > ONE_C;
        w_lum_over   = CMP_W'(i_lum_q) > ONE_C;
        w_alpha_over = CMP_W'(i_alpha_q) > ONE_C;
        w_hue        = w_hue_over ? HUE_MAX : i_hue_deg;
        w_sat        = w_sat_over ? Q_W'(ONE_C) : i_sat_q;
        w_lum        = w_lum_over ? Q_W'(ONE_C) : i_lum_q;
        w_alpha      = w_alpha_over ? Q_W'(ONE_C) : i_alpha_q;
    end

    // sector of the hue and triangle weight 60-|h mod 120 - 60|
    always_comb begin
        if (w_hue < HUE_W'(SECTOR_DEG)) begin
            w_sec = SEC_0;
        end else if (w_hue < HUE_W'(2 * SECTOR_DEG)) begin
            w_sec = SEC_1;
        end else if (w_hue < HUE_W'(3 * SECTOR_DEG)) begin
            w_sec = SEC_2;
        end else if (w_hue < HUE_W'(4 * SECTOR_DEG)) begin
            w_sec = SEC_3;
        end else if (w_hue < HUE_W'(5 * SECTOR_DEG)) begin
            w_sec = SEC_4;
        end else begin
            w_sec = SEC_5;
        end
        w_off = w_hue - sector_start(w_sec);
        if (w_sec[0]) begin
            w_k = K_W'(HUE_W'(SECTOR_DEG) - w_off);
        end else begin
            w_k = K_W'(w_off);
        end
    end

    // chroma factor 1-|2l-1|
    always_comb begin
        w_two_l = CMP_W'(w_lum) << 1;
        w_dist  = (w_two_l >= ONE_C) ? (w_two_l - ONE_C) : (ONE_C - w_two_l);
        w_a     = A_W'(ONE_C - w_dist);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_sec   <= w_sec;
            r1_k     <= w_k;
            r1_a     <= w_a;
            r1_sat   <= w_sat;
            r1_lum   <= w_lum;
            r1_alpha <= w_alpha;
            r1_err   <= w_hue_over | w_sat_over | w_lum_over | w_alpha_over;
        end
    end

    // ---------------- stage 2: chroma ----------------
    t_sector          r2_sec;
    logic [K_W-1:0]   r2_k;
    logic [C2_W-1:0]  r2_c2;
    logic [Q_W-1:0]   r2_lum, r2_alpha;
    logic             r2_err;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_sec   <= r1_sec;
            r2_k     <= r1_k;
            r2_c2    <= C2_W'(r1_a) * C2_W'(r1_sat);
            r2_lum   <= r1_lum;
            r2_alpha <= r1_alpha;
            r2_err   <= r1_err;
        end
    end

    // ---------------- stage 3: channel numerators ----------------
    logic [V_W-1:0]   w_mn, w_cn, w_xn;

    t_sector          r3_sec;
    logic [V_W-1:0]   r3_vc, r3_vx, r3_vm;
    logic [Q_W-1:0]   r3_alpha;
    logic             r3_err;

    // m = l - c/2, c and x, all over one*one*120
    always_comb begin
        w_mn = ((V_W'(r2_lum) * V_W'(2 * SECTOR_DEG)) << FRAC_BITS)
             - V_W'(r2_c2) * V_W'(SECTOR_DEG);
        w_cn = V_W'(r2_c2) * V_W'(2 * SECTOR_DEG);
        w_xn = (V_W'(r2_c2) * V_W'(r2_k)) << 1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_sec   <= r2_sec;
            r3_vc    <= w_cn + w_mn;
            r3_vx    <= w_xn + w_mn;
            r3_vm    <= w_mn;
            r3_alpha <= r2_alpha;
            r3_err   <= r2_err;
        end
    end

    // ---------------- stage 4: channel routing and rounding ----------------
    logic [V_W-1:0]   w_vr, w_vg, w_vb;

    logic [CH_W-1:0]  r4_red, r4_green, r4_blue;
    logic [Q_W-1:0]   r4_alpha;
    logic             r4_err;

    // sector decides which channel takes c+m, x+m or m
    always_comb begin
        case (r3_sec)
            SEC_0: begin
                w_vr = r3_vc; w_vg = r3_vx; w_vb = r3_vm;
            end
            SEC_1: begin
                w_vr = r3_vx; w_vg = r3_vc; w_vb = r3_vm;
            end
            SEC_2: begin
                w_vr = r3_vm; w_vg = r3_vc; w_vb = r3_vx;
            end
            SEC_3: begin
                w_vr = r3_vm; w_vg = r3_vx; w_vb = r3_vc;
            end
            SEC_4: begin
                w_vr = r3_vx; w_vg = r3_vm; w_vb = r3_vc;
            end
            default: begin
                w_vr = r3_vc; w_vg = r3_vm; w_vb = r3_vx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r4_red   <= to_byte(w_vr);
            r4_green <= to_byte(w_vg);
            r4_blue  <= to_byte(w_vb);
            r4_alpha <= r3_alpha;
            r4_err   <= r3_err;
        end
    end

    assign o_red_out     = r4_red;
    assign o_green_out   = r4_green;
    assign o_blue_out    = r4_blue;
    assign o_alpha_out   = r4_alpha;
    assign o_range_error = r4_err;

endmodule

// File: hdl/hsl_to_rgb_converter.sv
// channel   direction   contents
// i_hsl     in          hue_deg, sat_q, lum_q, alpha_q (valid/ready)
// o_rgb     out         red_out, green_out, blue_out, alpha_out, range_error
//
// four register stages: clamp and sector, chroma multiply, channel
// numerators, routing and rounding; one colour per cycle without a stall
// the chroma multiply (FRAC_BITS+1 by 13 bits) sets the longest stage
// reset clears the stage valid bits only
// each stage holds while it is full and the stage after it is blocked, so
// empty stages close up under a stall and o_rgb.ready reaches i_hsl.ready
`include "hsl_to_rgb_converter_macros.svh"

module hsl_to_rgb_converter import hsl2rgb_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    hsl2rgb_in_if.sink     i_hsl,
    hsl2rgb_out_if.source  o_rgb
);

    localparam int CMP_W = (FRAC_BITS + 1 > Q_W + 1) ? FRAC_BITS + 1 : Q_W + 1;
    localparam logic [CMP_W-1:0] ONE_C = CMP_W'(1) << FRAC_BITS;

    logic [STAGES-1:0] r_vld, n_vld;
    logic [STAGES-1:0] w_en;
    logic              w_in_acc, w_out_acc;

    // stage enables, from the output back to the input
    always_comb begin
        w_en[STAGES-1] = !r_vld[STAGES-1] | o_rgb.ready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            w_en[i] = !r_vld[i] | w_en[i+1];
        end
    end

    // valid bits travel with the data
    always_comb begin
        n_vld = r_vld;
        if (w_en[0]) begin
            n_vld[0] = i_hsl.valid;
        end
        for (int i = 1; i < STAGES; i++) begin
            if (w_en[i]) begin
                n_vld[i] = r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_hsl.ready = w_en[0];
    assign o_rgb.valid = r_vld[STAGES-1];
    assign w_in_acc    = i_hsl.valid & i_hsl.ready;
    assign w_out_acc   = o_rgb.valid & o_rgb.ready;

    // arithmetic stages
    hsl2rgb_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_en          (w_en),
        .i_hue_deg     (i_hsl.hue_deg),
        .i_sat_q       (i_hsl.sat_q),
        .i_lum_q       (i_hsl.lum_q),
        .i_alpha_q     (i_hsl.alpha_q),
        .o_red_out     (o_rgb.red_out),
        .o_green_out   (o_rgb.green_out),
        .o_blue_out    (o_rgb.blue_out),
        .o_alpha_out   (o_rgb.alpha_out),
        .o_range_error (o_rgb.range_error)
    );

    // input is only refused with every stage occupied
    `HSL2RGB_ASSERT_IMP(a_full_when_refused, i_clk, i_rst_n, !i_hsl.ready, &r_vld, "input refused with an empty stage")
    // an accepted transaction lands in the first stage
    `HSL2RGB_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, w_in_acc, r_vld[0], "accepted transaction lost at entry")
    // items in flight change only by transactions on either side
    `HSL2RGB_ASSERT_HOLDS(a_count_kept, i_clk, i_rst_n, ($countones(r_vld) == ($past($countones(r_vld)) + int'($past(w_in_acc)) - int'($past(w_out_acc)))) || $past(!i_rst_n), "items in flight lost or duplicated")
    // alpha leaves clamped to one
    `HSL2RGB_ASSERT_IMP(a_alpha_clamped, i_clk, i_rst_n, o_rgb.valid, CMP_W'(o_rgb.alpha_out) <= ONE_C, "alpha above one at output")

endmodule

// File: dv/hsl_to_rgb_converter_test.sv
`timescale 1ns / 1ps

module hsl_to_rgb_converter_test;
    import hsl2rgb_pkg::*;

    localparam int FRAC_BITS  = FRAC_BITS_DEF;
    localparam int Q_TOP      = (FRAC_BITS >= Q_W) ? (1 << Q_W) - 1 : (1 << FRAC_BITS);
    localparam int N_RANDOM   = 830;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_WAIT = 2 * STAGES + 4;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [Q_W-1:0]   sat;
        logic [Q_W-1:0]   lum;
        logic [Q_W-1:0]   alpha;
    } t_hsl;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [Q_W-1:0]  alpha;
        logic            range_err;
    } t_rgb;

    logic i_clk;
    logic i_rst_n;

    hsl2rgb_in_if  hsl_ch ();
    hsl2rgb_out_if rgb_ch ();

    hsl_to_rgb_converter #(
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hsl   (hsl_ch),
        .o_rgb   (rgb_ch)
    );

    t_hsl pending_hsl[$];
    t_rgb expected_rgb[$];
    t_hsl next_hsl;
    t_rgb got_rgb;
    t_rgb want_rgb;
    int   colours_total;
    int   colours_accepted;
    int   mismatches;
    int   src_gap_left;
    int   sink_stall_left;
    int   idle_cycles;
    int   cycle_cnt;

    // clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic logic [63:0] abs_diff(logic [63:0] a, logic [63:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // 255 * num / den, rounded half up and capped at full scale
    function automatic logic [CH_W-1:0] to_channel(logic [63:0] num, logic [63:0] den);
        logic [63:0] r;
        r = (64'(CHAN_MAX) * num * 2 + den) / (den * 2);
        if (r > CHAN_MAX)
            r = CHAN_MAX;
        return r[CH_W-1:0];
    endfunction

    // exact conversion over the common denominator one*one*120
    function automatic t_rgb hsl_to_rgb(t_hsl px);
        logic [63:0] one, h, s, l, a, den, c2, cn, xn, mn, t, rn, gn, bn;
        t_sector     sec;
        t_rgb        res;
        one = 64'd1 << FRAC_BITS;
        h = px.hue;
        s = px.sat;
        l = px.lum;
        a = px.alpha;
        res.range_err = 1'b0;
        if (h > 360) begin
            h = 360;
            res.range_err = 1'b1;
        end
        if (s > one) begin
            s = one;
            res.range_err = 1'b1;
        end
        if (l > one) begin
            l = one;
            res.range_err = 1'b1;
        end
        if (a > one) begin
            a = one;
            res.range_err = 1'b1;
        end
        den = one * one * 2 * SECTOR_DEG;
        c2  = (one - abs_diff(2 * l, one)) * s;
        cn  = c2 * 2 * SECTOR_DEG;
        t   = h % (2 * SECTOR_DEG);
        xn  = c2 * 2 * (SECTOR_DEG - abs_diff(t, SECTOR_DEG));
        mn  = l * one * 2 * SECTOR_DEG - c2 * SECTOR_DEG;
        // hue 360 joins the last sector
        sec = (h >= 5 * SECTOR_DEG) ? SEC_5 : t_sector'(h / SECTOR_DEG);
        case (sec)
            SEC_0: begin
                rn = cn + mn; gn = xn + mn; bn = mn;
            end
            SEC_1: begin
                rn = xn + mn; gn = cn + mn; bn = mn;
            end
            SEC_2: begin
                rn = mn; gn = cn + mn; bn = xn + mn;
            end
            SEC_3: begin
                rn = mn; gn = xn + mn; bn = cn + mn;
            end
            SEC_4: begin
                rn = xn + mn; gn = mn; bn = cn + mn;
            end
            default: begin
                rn = cn + mn; gn = mn; bn = xn + mn;
            end
        endcase
        res.red   = to_channel(rn, den);
        res.green = to_channel(gn, den);
        res.blue  = to_channel(bn, den);
        res.alpha = a[Q_W-1:0];
        return res;
    endfunction

    // gap length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 93)
            return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < 40)
            $display("error at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task automatic add_hsl(input int h, input int s, input int l, input int a);
        t_hsl px;
        px.hue   = h[HUE_W-1:0];
        px.sat   = s[Q_W-1:0];
        px.lum   = l[Q_W-1:0];
        px.alpha = a[Q_W-1:0];
        pending_hsl.push_back(px);
    endtask

    // hsl driver: takes colours from the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hsl_ch.valid <= 1'b0;
            src_gap_left <= 0;
        end else begin
            // predict on each accepted transaction
            if (hsl_ch.valid && hsl_ch.ready) begin
                expected_rgb.push_back(hsl_to_rgb({hsl_ch.hue_deg, hsl_ch.sat_q,
                                                   hsl_ch.lum_q, hsl_ch.alpha_q}));
                colours_accepted++;
            end
            if (!hsl_ch.valid || hsl_ch.ready) begin
                if (src_gap_left > 0) begin
                    hsl_ch.valid <= 1'b0;
                    src_gap_left <= src_gap_left - 1;
                end else if (pending_hsl.size() > 0) begin
                    next_hsl = pending_hsl.pop_front();
                    hsl_ch.hue_deg <= next_hsl.hue;
                    hsl_ch.sat_q   <= next_hsl.sat;
                    hsl_ch.lum_q   <= next_hsl.lum;
                    hsl_ch.alpha_q <= next_hsl.alpha;
                    hsl_ch.valid   <= 1'b1;
                    if ((cycle_cnt % 700) >= 200 && $urandom_range(0, 99) < 35)
                        src_gap_left <= pick_gap();
                end else begin
                    hsl_ch.valid <= 1'b0;
                end
            end
        end
    end

    // rgb sink back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rgb_ch.ready    <= 1'b0;
            sink_stall_left <= 0;
        end else if (sink_stall_left > 0) begin
            rgb_ch.ready    <= 1'b0;
            sink_stall_left <= sink_stall_left - 1;
        end else if ((cycle_cnt % 600) < 150 || $urandom_range(0, 99) >= 30) begin
            rgb_ch.ready <= 1'b1;
        end else begin
            rgb_ch.ready    <= 1'b0;
            sink_stall_left <= pick_gap() - 1;
        end
    end

    // rgb monitor: compare against the oldest predicted colour
    always @(posedge i_clk) begin
        if (i_rst_n && rgb_ch.valid && rgb_ch.ready) begin
            got_rgb = {rgb_ch.red_out, rgb_ch.green_out, rgb_ch.blue_out,
                       rgb_ch.alpha_out, rgb_ch.range_error};
            if (expected_rgb.size() == 0) begin
                report_mismatch("rgb transaction with no colour outstanding");
            end else begin
                want_rgb = expected_rgb.pop_front();
                check_field("red_out", got_rgb.red, want_rgb.red);
                check_field("green_out", got_rgb.green, want_rgb.green);
                check_field("blue_out", got_rgb.blue, want_rgb.blue);
                check_field("alpha_out", got_rgb.alpha, want_rgb.alpha);
                check_field("range_error", got_rgb.range_err, want_rgb.range_err);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (!i_rst_n || (hsl_ch.valid && hsl_ch.ready) || (rgb_ch.valid && rgb_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("hsl_to_rgb_converter: mismatch");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        int kind;
        int h;
        int s;
        int l;
        int a;
        i_rst_n          = 1'b0;
        hsl_ch.valid     = 1'b0;
        hsl_ch.hue_deg   = '0;
        hsl_ch.sat_q     = '0;
        hsl_ch.lum_q     = '0;
        hsl_ch.alpha_q   = '0;
        rgb_ch.ready     = 1'b0;
        colours_accepted = 0;
        mismatches       = 0;
        idle_cycles      = 0;
        cycle_cnt        = 0;

        // primaries, sector edges, clamping and greys
        add_hsl(0, 0, 0, 0);
        add_hsl(0, Q_TOP, Q_TOP / 2, Q_TOP);
        add_hsl(59, Q_TOP, Q_TOP / 2, 1);
        add_hsl(60, Q_TOP, Q_TOP / 2, 0);
        add_hsl(119, Q_TOP, Q_TOP / 2, 2);
        add_hsl(120, Q_TOP, Q_TOP / 2, 3);
        add_hsl(179, Q_TOP, Q_TOP / 2, 4);
        add_hsl(180, Q_TOP, Q_TOP / 2, 5);
        add_hsl(239, Q_TOP, Q_TOP / 2, 6);
        add_hsl(240, Q_TOP, Q_TOP / 2, 7);
        add_hsl(299, Q_TOP, Q_TOP / 2, 8);
        add_hsl(300, Q_TOP, Q_TOP / 2, 9);
        add_hsl(359, Q_TOP, Q_TOP / 2, Q_TOP - 1);
        add_hsl(360, Q_TOP, Q_TOP / 2, Q_TOP);
        add_hsl(361, Q_TOP, Q_TOP / 2, Q_TOP);
        add_hsl(511, 8191, 8191, 8191);
        add_hsl(90, Q_TOP + 1, Q_TOP / 2, 0);
        add_hsl(200, Q_TOP / 2, Q_TOP + 1, 0);
        add_hsl(30, Q_TOP / 2, Q_TOP / 2, Q_TOP + 1);
        add_hsl(45, Q_TOP, Q_TOP, 100);
        add_hsl(150, 0, Q_TOP / 4, Q_TOP);
        add_hsl(270, 1234, 3000, 77);
        add_hsl(330, Q_TOP, 1, 8191);
        add_hsl(10, 3000, Q_TOP - 1, 0);

        // random colours: mostly in range, some on sector edges, some raw
        for (int n = 0; n < N_RANDOM; n++) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                h = $urandom_range(0, 360);
                s = $urandom_range(0, Q_TOP);
                l = $urandom_range(0, Q_TOP);
                a = $urandom_range(0, Q_TOP);
            end else if (kind < 8) begin
                h = SECTOR_DEG * $urandom_range(0, 6) + $urandom_range(0, 1);
                s = ($urandom_range(0, 1) == 0) ? Q_TOP : $urandom_range(0, Q_TOP);
                l = $urandom_range(0, Q_TOP);
                a = $urandom_range(0, 8191);
            end else begin
                h = $urandom_range(0, 511);
                s = $urandom_range(0, 8191);
                l = $urandom_range(0, 8191);
                a = $urandom_range(0, 8191);
            end
            add_hsl(h, s, l, a);
        end
        colours_total = pending_hsl.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (colours_accepted < colours_total)
            @(posedge i_clk);
        while (expected_rgb.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0)
            $display("hsl_to_rgb_converter: match");
        else
            $display("hsl_to_rgb_converter: mismatch");
        $finish;
    end

endmodule
